// ===== sv/tgi_pkg.sv =====
package tgi_pkg;

  localparam int SizeW   = 6;
  localparam int IdxW    = 5;
  localparam int SampleW = 16;
  localparam int FracW   = 16;
  localparam int CoordW  = FracW + 1;
  localparam int MaxDim  = 32;
  localparam int NBanks  = 8;
  localparam int BankAw  = 3 * (IdxW - 1);
  localparam int BankDepth = 1 << BankAw;
  localparam int ProdW   = CoordW + SizeW;

  typedef enum logic [1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IdxW-1:0]   lo;
    logic [IdxW-1:0]   hi;
    logic [CoordW-1:0] frac;
  } axis_t;

  // Scale a normalized coordinate by the grid size, split into base and fraction.
  function automatic axis_t split_axis(input logic [CoordW-1:0] coord,
                                       input logic [SizeW-1:0] size);
    logic [SizeW-1:0] n;
    logic [ProdW-1:0] p;
    logic [ProdW-1:0] base;
    logic [ProdW-1:0] f;
    logic [SizeW-1:0] up;
    axis_t            a;
    if (size == '0) n = SizeW'(1);
    else if (size > SizeW'(MaxDim)) n = SizeW'(MaxDim);
    else n = size;
    p    = ProdW'(coord) * ProdW'(n);
    base = p >> FracW;
    if (base > ProdW'(n - SizeW'(1))) base = ProdW'(n - SizeW'(1));
    f = p - (base << FracW);
    if (f > (ProdW'(1) << FracW)) f = ProdW'(1) << FracW;
    a.lo   = base[IdxW-1:0];
    up     = SizeW'(a.lo) + SizeW'(1);
    a.hi   = (up < n) ? up[IdxW-1:0] : IdxW'(n - SizeW'(1));
    a.frac = f[CoordW-1:0];
    return a;
  endfunction

  // a + floor(((b - a) * f + half) / one); stays between a and b.
  function automatic logic signed [SampleW-1:0] lerp(input logic signed [SampleW-1:0] a,
                                                     input logic signed [SampleW-1:0] b,
                                                     input logic [CoordW-1:0] f);
    logic signed [SampleW:0]          d;
    logic signed [SampleW+CoordW+1:0] t;
    logic signed [SampleW+2:0]        s;
    d = (SampleW+1)'(b) - (SampleW+1)'(a);
    t = (SampleW+CoordW+2)'(d) * (SampleW+CoordW+2)'(signed'({1'b0, f}));
    t = t + (SampleW+CoordW+2)'(1 << (FracW - 1));
    s = (SampleW+3)'(t >>> FracW);
    s = s + (SampleW+3)'(a);
    return s[SampleW-1:0];
  endfunction

endpackage

// ===== sv/tgi_ram.sv =====
module tgi_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/trilinear_grid_interpolator.sv =====
// Trilinear interpolator over a 32x32x32 grid of signed 16-bit samples.
// Each item is either a sample write (req_type 0) or a query (req_type 1)
// with Q1.16 coordinates; a query returns one rounded, interpolated value,
// a write returns nothing. The block takes one item per cycle while the
// output is not stalled; a query's result moves through the stages below
// into the output register. The grid is held in eight banks by index parity,
// so a cell's eight corners are all read together. Stages: split coordinates,
// bank read (writes are applied here too, keeping program order), four x
// blends, two y blends, one z blend into the output register. The whole
// pipeline advances together whenever the output register is free or being
// taken. Sample memory has no reset: only read samples that have been written.
module trilinear_grid_interpolator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [tgi_pkg::SizeW-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [tgi_pkg::IdxW-1:0]           write_x_i,
  input  logic [tgi_pkg::IdxW-1:0]           write_y_i,
  input  logic [tgi_pkg::IdxW-1:0]           write_z_i,
  input  logic signed [tgi_pkg::SampleW-1:0] sample_value_i,
  input  logic [tgi_pkg::CoordW-1:0]         coord_x_i,
  input  logic [tgi_pkg::CoordW-1:0]         coord_y_i,
  input  logic [tgi_pkg::CoordW-1:0]         coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tgi_pkg::SampleW-1:0] interp_value_o
);

  localparam int IW = tgi_pkg::IdxW;
  localparam int SW = tgi_pkg::SampleW;
  localparam int CW = tgi_pkg::CoordW;
  localparam int AW = tgi_pkg::BankAw;
  localparam int NB = tgi_pkg::NBanks;

  // Configuration registers.
  logic [tgi_pkg::SizeW-1:0] size_x_q, size_y_q, size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= tgi_pkg::SizeW'(tgi_pkg::MaxDim);
      size_y_q <= tgi_pkg::SizeW'(tgi_pkg::MaxDim);
      size_z_q <= tgi_pkg::SizeW'(tgi_pkg::MaxDim);
    end else if (cfg_we_i) begin
      unique case (tgi_pkg::cfg_idx_e'(cfg_idx_i))
        tgi_pkg::CFG_SIZE_X: size_x_q <= cfg_wdata_i;
        tgi_pkg::CFG_SIZE_Y: size_y_q <= cfg_wdata_i;
        tgi_pkg::CFG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register can take data.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: split coordinates; carry write fields.
  tgi_pkg::axis_t ax_d, ay_d, az_d;
  assign ax_d = tgi_pkg::split_axis(coord_x_i, size_x_q);
  assign ay_d = tgi_pkg::split_axis(coord_y_i, size_y_q);
  assign az_d = tgi_pkg::split_axis(coord_z_i, size_z_q);

  logic                  s1_valid_q, s1_query_q;
  tgi_pkg::axis_t        s1_ax_q, s1_ay_q, s1_az_q;
  logic [IW-1:0]         s1_wx_q, s1_wy_q, s1_wz_q;
  logic signed [SW-1:0]  s1_wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_query_q <= req_type_i;
      s1_ax_q    <= ax_d;
      s1_ay_q    <= ay_d;
      s1_az_q    <= az_d;
      s1_wx_q    <= write_x_i;
      s1_wy_q    <= write_y_i;
      s1_wz_q    <= write_z_i;
      s1_wdata_q <= sample_value_i;
    end
  end

  // Stage 2: bank read. Bank b holds samples whose index parities are b.
  logic [2:0]    wbank;
  logic [AW-1:0] waddr;
  logic          wr_en;
  assign wbank = {s1_wz_q[0], s1_wy_q[0], s1_wx_q[0]};
  assign waddr = {s1_wz_q[IW-1:1], s1_wy_q[IW-1:1], s1_wx_q[IW-1:1]};
  assign wr_en = adv && s1_valid_q && !s1_query_q;

  logic [SW-1:0] bank_rdata [NB];

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [IW-1:0] xa, ya, za;
    logic [AW-1:0] raddr;
    // Pick whichever neighbor has this bank's parity.
    assign xa    = (s1_ax_q.lo[0] == b[0]) ? s1_ax_q.lo : s1_ax_q.hi;
    assign ya    = (s1_ay_q.lo[0] == b[1]) ? s1_ay_q.lo : s1_ay_q.hi;
    assign za    = (s1_az_q.lo[0] == b[2]) ? s1_az_q.lo : s1_az_q.hi;
    assign raddr = {za[IW-1:1], ya[IW-1:1], xa[IW-1:1]};

    tgi_ram #(
      .Width(SW),
      .Depth(tgi_pkg::BankDepth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en && (wbank == 3'(b))),
      .waddr_i(waddr),
      .wdata_i(s1_wdata_q),
      .re_i   (adv),
      .raddr_i(raddr),
      .rdata_o(bank_rdata[b])
    );
  end

  logic          s2_valid_q;
  logic [1:0]    s2_px_q, s2_py_q, s2_pz_q;  // {hi parity, lo parity}
  logic [CW-1:0] s2_fx_q, s2_fy_q, s2_fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (adv) s2_valid_q <= s1_valid_q && s1_query_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_px_q <= {s1_ax_q.hi[0], s1_ax_q.lo[0]};
      s2_py_q <= {s1_ay_q.hi[0], s1_ay_q.lo[0]};
      s2_pz_q <= {s1_az_q.hi[0], s1_az_q.lo[0]};
      s2_fx_q <= s1_ax_q.frac;
      s2_fy_q <= s1_ay_q.frac;
      s2_fz_q <= s1_az_q.frac;
    end
  end

  // Stage 3: route banks to corners, blend along x.
  // corner[c] with c = {z hi, y hi, x hi}.
  logic signed [SW-1:0] corner [8];
  for (genvar c = 0; c < 8; c++) begin : g_corner
    assign corner[c] = bank_rdata[{s2_pz_q[c/4], s2_py_q[(c/2)%2], s2_px_q[c%2]}];
  end

  logic signed [SW-1:0] vx_d [4];
  for (genvar k = 0; k < 4; k++) begin : g_xlerp
    assign vx_d[k] = tgi_pkg::lerp(corner[2*k], corner[2*k+1], s2_fx_q);
  end

  logic                 s3_valid_q;
  logic signed [SW-1:0] s3_v_q [4];
  logic [CW-1:0]        s3_fy_q, s3_fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else if (adv) s3_valid_q <= s2_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_v_q  <= vx_d;
      s3_fy_q <= s2_fy_q;
      s3_fz_q <= s2_fz_q;
    end
  end

  // Stage 4: blend along y (index bit 0 of s3_v_q is y hi, bit 1 is z hi).
  logic                 s4_valid_q;
  logic signed [SW-1:0] s4_v0_q, s4_v1_q;
  logic [CW-1:0]        s4_fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else if (adv) s4_valid_q <= s3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_v0_q <= tgi_pkg::lerp(s3_v_q[0], s3_v_q[1], s3_fy_q);
      s4_v1_q <= tgi_pkg::lerp(s3_v_q[2], s3_v_q[3], s3_fy_q);
      s4_fz_q <= s3_fz_q;
    end
  end

  // Stage 5: blend along z into the output register. A blend never leaves
  // the span of its two inputs, so the value is already in sample range.
  logic signed [SW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= tgi_pkg::lerp(s4_v0_q, s4_v1_q, s4_fz_q);
  end

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_q;

endmodule

// ===== dv/trilinear_grid_interpolator_tb.sv =====
`timescale 1ns / 1ps

module trilinear_grid_interpolator_tb;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 12;
  localparam int TotalItems    = 1850;

  localparam int IdxW    = tgi_pkg::IdxW;
  localparam int SampleW = tgi_pkg::SampleW;
  localparam int CoordW  = tgi_pkg::CoordW;
  localparam int SizeW   = tgi_pkg::SizeW;
  localparam int MaxDim  = tgi_pkg::MaxDim;
  localparam int FracW   = tgi_pkg::FracW;

  typedef struct {
    bit                       is_query;
    bit [IdxW-1:0]            wx, wy, wz;
    logic signed [SampleW-1:0] value;
    bit [CoordW-1:0]          cx, cy, cz;
  } grid_item_t;

  typedef struct {
    int  lo;
    int  hi;
    longint frac;
  } corner_span_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [1:0]                 cfg_idx_i = tgi_pkg::CFG_NONE;
  logic [SizeW-1:0]           cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       req_type_i = 1'b0;
  logic [IdxW-1:0]            write_x_i = '0, write_y_i = '0, write_z_i = '0;
  logic signed [SampleW-1:0]  sample_value_i = '0;
  logic [CoordW-1:0]          coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SampleW-1:0]  interp_value_o;

  trilinear_grid_interpolator u_dut (.*);

  // 8 ns clock: high then low
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: grid contents, which entries were written, sizes in use
  logic signed [SampleW-1:0] grid_mirror [MaxDim*MaxDim*MaxDim];
  bit                        grid_written [MaxDim*MaxDim*MaxDim];
  logic [SizeW-1:0]          mirror_size [3];

  grid_item_t                pending_items [$];
  logic signed [SampleW-1:0] expected_values [$];

  bit failed;
  bit quiet;             // no idling on either side in the last part
  bit item_taken;
  int sender_gap;
  int receiver_gap;
  int long_hold;
  bit long_hold_done;
  int results_seen;
  int quiet_cycles;

  function automatic int grid_addr(int x, int y, int z);
    return x + MaxDim * (y + MaxDim * z);
  endfunction

  function automatic corner_span_t span_axis(bit [CoordW-1:0] coord, logic [SizeW-1:0] size);
    corner_span_t s;
    longint n, p, base;
    n = (size == 0) ? 1 : (size > MaxDim) ? MaxDim : size;
    p = longint'(coord) * n;
    base = p >> FracW;
    if (base > n - 1) base = n - 1;
    s.frac = p - (base << FracW);
    if (s.frac > (longint'(1) << FracW)) s.frac = longint'(1) << FracW;
    s.lo = int'(base);
    s.hi = (base + 1 < n) ? int'(base + 1) : int'(n - 1);
    return s;
  endfunction

  // Round half up: floor((b - a) * f + half) >> FracW
  function automatic longint blend(longint a, longint b, longint f);
    longint t;
    t = (b - a) * f + (longint'(1) << (FracW - 1));
    return a + (t >>> FracW);
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic bit [CoordW-1:0] random_coord();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return CoordW'(1 << FracW);
      2: return CoordW'((1 << FracW) - 1);
      3: return '1;
      4: return CoordW'($urandom);
      default: return CoordW'($urandom_range(0, 1 << FracW));
    endcase
  endfunction

  task automatic queue_write(int x, int y, int z, logic signed [SampleW-1:0] v);
    grid_item_t it;
    it.is_query = 1'b0;
    it.wx = IdxW'(x); it.wy = IdxW'(y); it.wz = IdxW'(z);
    it.value = v;
    it.cx = CoordW'($urandom); it.cy = CoordW'($urandom); it.cz = CoordW'($urandom);
    grid_mirror[grid_addr(x, y, z)] = v;
    grid_written[grid_addr(x, y, z)] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Fill any unwritten corner first, then queue the query and its expected value
  task automatic queue_query(bit [CoordW-1:0] cx, bit [CoordW-1:0] cy, bit [CoordW-1:0] cz);
    grid_item_t   it;
    corner_span_t ax, ay, az;
    int           xs [2], ys [2], zs [2];
    longint       c [8];
    longint       v0, v1, r;
    ax = span_axis(cx, mirror_size[tgi_pkg::CFG_SIZE_X]);
    ay = span_axis(cy, mirror_size[tgi_pkg::CFG_SIZE_Y]);
    az = span_axis(cz, mirror_size[tgi_pkg::CFG_SIZE_Z]);
    xs = '{ax.lo, ax.hi}; ys = '{ay.lo, ay.hi}; zs = '{az.lo, az.hi};
    for (int k = 0; k < 8; k++) begin
      if (!grid_written[grid_addr(xs[k[0]], ys[k[1]], zs[k[2]])])
        queue_write(xs[k[0]], ys[k[1]], zs[k[2]], random_sample());
      c[k] = grid_mirror[grid_addr(xs[k[0]], ys[k[1]], zs[k[2]])];
    end
    v0 = blend(blend(c[0], c[1], ax.frac), blend(c[2], c[3], ax.frac), ay.frac);
    v1 = blend(blend(c[4], c[5], ax.frac), blend(c[6], c[7], ax.frac), ay.frac);
    r = blend(v0, v1, az.frac);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    it.is_query = 1'b1;
    it.wx = IdxW'($urandom); it.wy = IdxW'($urandom); it.wz = IdxW'($urandom);
    it.value = SampleW'($urandom);
    it.cx = cx; it.cy = cy; it.cz = cz;
    pending_items.push_back(it);
    expected_values.push_back(SampleW'(r));
  endtask

  // Register writes go out one per cycle on the falling edge
  task automatic set_sizes(logic [SizeW-1:0] sx, logic [SizeW-1:0] sy, logic [SizeW-1:0] sz);
    logic [SizeW-1:0]  vals [3];
    tgi_pkg::cfg_idx_e idx [3];
    vals = '{sx, sy, sz};
    idx = '{tgi_pkg::CFG_SIZE_X, tgi_pkg::CFG_SIZE_Y, tgi_pkg::CFG_SIZE_Z};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[k];
      cfg_wdata_i <= vals[k];
      mirror_size[idx[k]] = vals[k];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_idx_i <= tgi_pkg::CFG_NONE;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_values.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random mix: mostly well-formed queries (corners filled on demand), some stray writes
  task automatic run_random(int n_items);
    int start;
    start = pending_items.size();
    while (pending_items.size() - start < n_items) begin
      if ($urandom_range(0, 3) == 0)
        queue_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                    random_sample());
      else
        queue_query(random_coord(), random_coord(), random_coord());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme samples, half-way tie, coordinates at and past 1.0
    set_sizes(6'd32, 6'd32, 6'd32);
    queue_write(0, 0, 0, 16'sh8000);
    queue_write(1, 0, 0, 16'sh7fff);
    queue_write(31, 31, 31, 16'sh7fff);
    queue_query(CoordW'(1024), '0, '0);
    queue_query('0, '0, '0);
    queue_query(CoordW'(1 << FracW), CoordW'(1 << FracW), CoordW'(1 << FracW));
    queue_query('1, '1, '1);
    queue_query(CoordW'((1 << FracW) - 1), CoordW'(1 << (FracW - 1)), CoordW'(1));
    queue_query(CoordW'(1024 + 1), CoordW'(2047), CoordW'(33000));
    wait_drained();

    // Size zero behaves as one, sizes above the grid saturate
    set_sizes(6'd0, 6'd63, 6'd33);
    queue_query(CoordW'(40000), CoordW'(40000), '1);
    run_random(200);
    wait_drained();

    set_sizes(6'd1, 6'd1, 6'd1);
    run_random(120);
    wait_drained();

    set_sizes(6'd2, 6'd5, 6'd17);
    run_random(250);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      set_sizes(SizeW'($urandom_range(0, 63)), SizeW'($urandom_range(0, 63)),
                SizeW'($urandom_range(0, 63)));
      run_random(250);
      wait_drained();
    end

    // Last part: full grid, no idling
    set_sizes(6'd32, 6'd32, 6'd32);
    quiet = 1'b1;
    run_random(250);
    wait_drained();

    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Track acceptance for the driver and the watchdog
  always @(posedge clk_i) begin
    item_taken <= in_valid_i && in_ready_o;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Driver: hold the item until taken, then advance or idle for a burst
  always @(negedge clk_i) begin
    grid_item_t it;
    if (rst_ni && (!in_valid_i || item_taken)) begin
      if (sender_gap > 0) begin
        sender_gap <= sender_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= it.is_query;
        write_x_i <= it.wx;
        write_y_i <= it.wy;
        write_z_i <= it.wz;
        sample_value_i <= it.value;
        coord_x_i <= it.cx;
        coord_y_i <= it.cy;
        coord_z_i <= it.cz;
        if (!quiet && $urandom_range(0, 5) == 0) sender_gap <= $urandom_range(1, 4);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back up the pipeline
  always @(negedge clk_i) begin
    if (!long_hold_done && results_seen >= 150) begin
      long_hold_done <= 1'b1;
      long_hold <= 120;
      out_ready_i <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready_i <= 1'b0;
    end else if (receiver_gap > 0) begin
      receiver_gap <= receiver_gap - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      receiver_gap <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Monitor: compare each taken result with the oldest expected value
  always @(posedge clk_i) begin
    logic signed [SampleW-1:0] want;
    if (out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected result %0d", $time, interp_value_o);
        failed = 1'b1;
      end else begin
        want = expected_values.pop_front();
        if (interp_value_o !== want) begin
          $display("%0t: interp_value expected %0d actual %0d", $time, want, interp_value_o);
          failed = 1'b1;
        end
      end
    end
  end

endmodule
